// ----- rtl/roc_pkg.sv -----
// Shared widths, record types and elaboration-time constants for the radiator output correction.
package roc_pkg;

   // Field widths
   localparam int TEMP_BITS  = 16;
   localparam int POWER_BITS = 16;
   localparam int FRAC_BITS  = 16;

   // Stream word widths, padded to whole bytes
   localparam int REQ_W  = ((3 * TEMP_BITS + POWER_BITS + 7) / 8) * 8;
   localparam int RSP_W  = ((POWER_BITS + 7) / 8) * 8;
   localparam int USER_W = 2;

   // rsp_tuser bit positions
   localparam int USER_UPDATED   = 0;
   localparam int USER_SATURATED = 1;

   // Mantissas are Q30 values in [1,2)
   localparam int Q_BITS = 30;
   localparam int MANT_W = Q_BITS + 1;

   // Magnitude of flow + return - 2 * room for positive temperatures
   localparam int DIFF_W = TEMP_BITS;
   localparam int POS_W  = $clog2(DIFF_W);

   // Scale constants: d / 50 K = D / 10000, exponent 13 / 10
   localparam int RATIO_DEN = 10000;
   localparam int EXP_NUM   = 13;
   localparam int EXP_DEN   = 10;

   // Log and exponent widths
   localparam int INT_W  = (POS_W > 4) ? POS_W : 4;
   localparam int LOG_W  = INT_W + FRAC_BITS;
   localparam int T_W    = LOG_W + 4;
   localparam int Q_W    = LOG_W + 1;
   localparam int E_W    = Q_W + 1;
   localparam int N_W    = E_W - FRAC_BITS;
   localparam int SH_W   = ((N_W > 6) ? N_W : 6) + 2;
   localparam int P_W    = POWER_BITS + MANT_W;

   // Reciprocal of EXP_DEN, exact floor for every product below 2^T_W
   localparam int RECIP_K = T_W + 4;
   localparam int M_W     = RECIP_K - 3;
   localparam logic [63:0] RECIP_M64 = ((64'd1 << RECIP_K) + 64'(EXP_DEN) - 64'd1) / 64'(EXP_DEN);
   localparam logic [M_W-1:0] RECIP_M = RECIP_M64[M_W-1:0];

   // Integer square root, used at elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 64'd0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // log2 by leading one and repeated squaring, used at elaboration only
   function automatic logic [63:0] log2_fixed(input logic [63:0] x);
      int p;
      logic [63:0] y;
      logic [63:0] fr;
      p = 0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) p = i;
      end
      y = (p >= Q_BITS) ? (x >> (p - Q_BITS)) : (x << (Q_BITS - p));
      fr = '0;
      for (int k = 0; k < FRAC_BITS; k++) begin
         y = (y * y) >> Q_BITS;
         fr = fr << 1;
         if (y >= (64'd2 << Q_BITS)) begin
            y = y >> 1;
            fr[0] = 1'b1;
         end
      end
      return (64'(p) << FRAC_BITS) | fr;
   endfunction

   // 2^k-th root of two in Q30: 2^(2^-k)
   function automatic logic [63:0] exp_root_q30(input int k);
      logic [63:0] r;
      r = 64'd2 << Q_BITS;
      for (int j = 1; j <= k; j++) begin
         r = isqrt64(r << Q_BITS);
      end
      return r;
   endfunction

   localparam logic [63:0] LOG_DEN64 = log2_fixed(64'(RATIO_DEN));
   localparam logic [LOG_W-1:0] LOG_DEN = LOG_DEN64[LOG_W-1:0];

   // Per-item sideband carried alongside the arithmetic
   typedef struct packed {
      logic [POWER_BITS-1:0] rated;
      logic                  upd;
      logic                  run;
   } side_type;

   // Log pipeline record
   typedef struct packed {
      logic [MANT_W-1:0]    y;
      logic [FRAC_BITS-1:0] fr;
      logic [POS_W-1:0]     pos;
      side_type             side;
   } log_type;

   // Exponent pipeline record
   typedef struct packed {
      logic [MANT_W-1:0]    m;
      logic [FRAC_BITS-1:0] f;
      logic [N_W-1:0]       n;
      side_type             side;
   } exp_type;

endpackage

// ----- rtl/roc_log_pipe.sv -----
// Fraction bits of log2 by repeated squaring, one squaring per pipeline stage.
module roc_log_pipe (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  roc_pkg::log_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output roc_pkg::log_type out_data
);
   import roc_pkg::*;

   localparam int STAGES = FRAC_BITS;

   logic              valid_ff [STAGES];
   log_type           data_ff  [STAGES];
   logic [STAGES:0]   rdy;

   assign rdy[STAGES] = out_ready;
   assign in_ready    = rdy[0];
   assign out_valid   = valid_ff[STAGES-1];
   assign out_data    = data_ff[STAGES-1];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      log_type               cur;
      log_type               data_in;
      logic                  vin;
      logic [2*MANT_W-1:0]   prod;
      logic [MANT_W:0]       sq;

      if (k == 0) begin : g_first
         assign cur = in_data;
         assign vin = in_valid;
      end else begin : g_next
         assign cur = data_ff[k-1];
         assign vin = valid_ff[k-1];
      end

      // square, then take one bit and halve when the square reaches two
      assign prod = (2 * MANT_W)'(cur.y) * (2 * MANT_W)'(cur.y);
      assign sq   = prod[Q_BITS +: MANT_W + 1];

      always_comb begin
         data_in    = cur;
         data_in.fr = {cur.fr[FRAC_BITS-2:0], sq[MANT_W]};
         data_in.y  = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
      end

      assign rdy[k] = !valid_ff[k] || rdy[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            valid_ff[k] <= vin;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && vin) begin
            data_ff[k] <= data_in;
         end
      end
   end

endmodule

// ----- rtl/roc_exp_pipe.sv -----
// 2^f in Q30 as a product of roots of two, one fraction bit per pipeline stage.
module roc_exp_pipe (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  roc_pkg::exp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output roc_pkg::exp_type out_data
);
   import roc_pkg::*;

   localparam int STAGES = FRAC_BITS;

   logic              valid_ff [STAGES];
   exp_type           data_ff  [STAGES];
   logic [STAGES:0]   rdy;

   assign rdy[STAGES] = out_ready;
   assign in_ready    = rdy[0];
   assign out_valid   = valid_ff[STAGES-1];
   assign out_data    = data_ff[STAGES-1];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam logic [63:0]       ROOT64 = exp_root_q30(k + 1);
      localparam logic [MANT_W-1:0] ROOT   = ROOT64[MANT_W-1:0];

      exp_type               cur;
      exp_type               data_in;
      logic                  vin;
      logic [2*MANT_W-1:0]   prod;

      if (k == 0) begin : g_first
         assign cur = in_data;
         assign vin = in_valid;
      end else begin : g_next
         assign cur = data_ff[k-1];
         assign vin = valid_ff[k-1];
      end

      // most significant fraction bit first
      assign prod = (2 * MANT_W)'(cur.m) * (2 * MANT_W)'(ROOT);

      always_comb begin
         data_in = cur;
         if (cur.f[FRAC_BITS-1-k]) begin
            data_in.m = prod[Q_BITS +: MANT_W];
         end
      end

      assign rdy[k] = !valid_ff[k] || rdy[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            valid_ff[k] <= vin;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && vin) begin
            data_ff[k] <= data_in;
         end
      end
   end

endmodule

// ----- rtl/radiator_output_correction.sv -----
// Radiator output correction: rated * (d / 50 K)^1.3 by fixed-point log2 and exp2.
// Pipeline stages from an accepted req word to its rsp word:
//   2 input stages, 16 log squarings, 4 exponent stages, 16 exp2 products, 2 output.
// Throughput: one word per cycle while rsp is ready; every stage holds its own valid
//   bit; a stall backs up stage by stage, so gaps still fill while rsp is stalled.
// Reset clears all valid bits; payload registers are not reset.
module radiator_output_correction (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // flow_temp, return_temp, room_temp, rated_output
   input  logic [roc_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // output_watts
   output logic [roc_pkg::RSP_W-1:0]  rsp_tdata,
   // updated, saturated
   output logic [roc_pkg::USER_W-1:0] rsp_tuser
);
   import roc_pkg::*;

   localparam int DSUM_W  = TEMP_BITS + 2;
   localparam int SHIFT_W = $clog2(MANT_W);
   localparam logic [POWER_BITS-1:0] LIMIT = '1;

   // ready chain, output side first
   logic rdy_out, rdy_p, rdy_exp, rdy_d, rdy_c, rdy_b, rdy_a, rdy_log, rdy_1, rdy_0;

   // ---------------- stage 0: skip test and |flow + return - 2 * room|
   logic signed [TEMP_BITS-1:0] flow_s, ret_s, room_s;
   logic [POWER_BITS-1:0]       rated_w;
   logic signed [DSUM_W-1:0]    diff;
   logic [DSUM_W-1:0]           diff_abs;
   logic                        upd_w;

   logic                        v0_ff;
   logic [DIFF_W-1:0]           d0_ff, d0_in;
   side_type                    s0_ff, s0_in;

   assign flow_s  = $signed(req_tdata[0 +: TEMP_BITS]);
   assign ret_s   = $signed(req_tdata[TEMP_BITS +: TEMP_BITS]);
   assign room_s  = $signed(req_tdata[2 * TEMP_BITS +: TEMP_BITS]);
   assign rated_w = req_tdata[3 * TEMP_BITS +: POWER_BITS];

   assign diff     = DSUM_W'(flow_s) + DSUM_W'(ret_s) - (DSUM_W'(room_s) <<< 1);
   assign diff_abs = diff[DSUM_W-1] ? DSUM_W'(-diff) : DSUM_W'(diff);
   assign upd_w    = (flow_s > 0) && (ret_s > 0) && (room_s > 0);

   always_comb begin
      d0_in       = diff_abs[DIFF_W-1:0];
      s0_in.rated = rated_w;
      s0_in.upd   = upd_w;
      s0_in.run   = upd_w && (d0_in != '0) && (rated_w != '0);
   end

   assign rdy_0      = !v0_ff || rdy_1;
   assign req_tready = rdy_0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (rdy_0) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_0 && req_tvalid) begin
         d0_ff <= d0_in;
         s0_ff <= s0_in;
      end
   end

   // ---------------- stage 1: leading one and normalize to Q30
   logic [POS_W-1:0]   pos;
   logic [SHIFT_W-1:0] norm_sh;
   logic               v1_ff;
   log_type            l1_ff, l1_in;

   always_comb begin
      pos = '0;
      for (int i = 0; i < DIFF_W; i++) begin
         if (d0_ff[i]) pos = POS_W'(i);
      end
   end

   assign norm_sh = SHIFT_W'(Q_BITS) - SHIFT_W'(pos);

   always_comb begin
      l1_in.y    = MANT_W'(d0_ff) << norm_sh;
      l1_in.fr   = '0;
      l1_in.pos  = pos;
      l1_in.side = s0_ff;
   end

   assign rdy_1 = !v1_ff || rdy_log;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy_1) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_1 && v0_ff) begin
         l1_ff <= l1_in;
      end
   end

   // ---------------- log2 fraction bits
   logic    log_valid;
   log_type log_data;

   roc_log_pipe u_log (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_ready  (rdy_log),
      .in_data   (l1_ff),
      .out_valid (log_valid),
      .out_ready (rdy_a),
      .out_data  (log_data)
   );

   // ---------------- stage A: log2 D - log2 10000, sign and magnitude
   logic [LOG_W-1:0]        logd;
   logic signed [LOG_W:0]   lr;
   logic                    va_ff;
   logic [LOG_W-1:0]        a_ff, a_in;
   logic                    neg_a_ff, neg_a_in;
   side_type                sa_ff;

   assign logd     = {INT_W'(log_data.pos), log_data.fr};
   assign lr       = $signed({1'b0, logd}) - $signed({1'b0, LOG_DEN});
   assign neg_a_in = lr[LOG_W];
   assign a_in     = neg_a_in ? LOG_W'(-lr) : LOG_W'(lr);

   assign rdy_a = !va_ff || rdy_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (rdy_a) begin
         va_ff <= log_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && log_valid) begin
         a_ff     <= a_in;
         neg_a_ff <= neg_a_in;
         sa_ff    <= log_data.side;
      end
   end

   // ---------------- stage B: times 13
   logic           vb_ff;
   logic [T_W-1:0] t_ff, t_in;
   logic           neg_b_ff;
   side_type       sb_ff;

   assign t_in  = T_W'(a_ff) * T_W'(EXP_NUM);
   assign rdy_b = !vb_ff || rdy_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (rdy_b) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_b && va_ff) begin
         t_ff     <= t_in;
         neg_b_ff <= neg_a_ff;
         sb_ff    <= sa_ff;
      end
   end

   // ---------------- stage C: divide by 10 through the reciprocal
   logic [T_W+M_W-1:0] qprod;
   logic               vc_ff;
   logic [Q_W-1:0]     q_ff;
   logic               neg_c_ff;
   side_type           sc_ff;

   assign qprod = (T_W + M_W)'(t_ff) * (T_W + M_W)'(RECIP_M);
   assign rdy_c = !vc_ff || rdy_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (rdy_c) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_c && vb_ff) begin
         q_ff     <= qprod[RECIP_K +: Q_W];
         neg_c_ff <= neg_b_ff;
         sc_ff    <= sb_ff;
      end
   end

   // ---------------- stage D: signed exponent, floor and fraction
   logic signed [E_W-1:0] e_val;
   logic                  vd_ff;
   exp_type               x_ff, x_in;

   assign e_val = neg_c_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});

   always_comb begin
      x_in.m    = MANT_W'(64'd1 << Q_BITS);
      x_in.f    = e_val[FRAC_BITS-1:0];
      x_in.n    = e_val[E_W-1:FRAC_BITS];
      x_in.side = sc_ff;
   end

   assign rdy_d = !vd_ff || rdy_exp;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (rdy_d) begin
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_d && vc_ff) begin
         x_ff <= x_in;
      end
   end

   // ---------------- exp2 of the fraction
   logic    exp_valid;
   exp_type exp_data;

   roc_exp_pipe u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vd_ff),
      .in_ready  (rdy_exp),
      .in_data   (x_ff),
      .out_valid (exp_valid),
      .out_ready (rdy_p),
      .out_data  (exp_data)
   );

   // ---------------- stage P: rated * mantissa
   logic           vp_ff;
   logic [P_W-1:0] p_ff, p_in;
   logic [N_W-1:0] n_ff;
   logic           upd_p_ff, run_p_ff;

   assign p_in  = P_W'(exp_data.side.rated) * P_W'(exp_data.m);
   assign rdy_p = !vp_ff || rdy_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (rdy_p) begin
         vp_ff <= exp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_p && exp_valid) begin
         p_ff     <= p_in;
         n_ff     <= exp_data.n;
         upd_p_ff <= exp_data.side.upd;
         run_p_ff <= exp_data.side.run;
      end
   end

   // ---------------- output stage: scale by 2^n, truncate and clamp
   logic [SH_W-1:0]       out_sh;
   logic [P_W-1:0]        heat_wide;
   logic [POWER_BITS-1:0] heat_ff, heat_in;
   logic                  sat_ff, sat_in;
   logic                  upd_ff;
   logic                  out_valid_ff;

   assign out_sh = SH_W'(Q_BITS) - SH_W'($signed(n_ff));

   always_comb begin
      heat_in   = '0;
      sat_in    = 1'b0;
      heat_wide = '0;
      if (run_p_ff) begin
         if ($signed(n_ff) > Q_BITS) begin
            heat_in = LIMIT;
            sat_in  = 1'b1;
         end else begin
            if (out_sh < SH_W'(P_W)) begin
               heat_wide = p_ff >> out_sh;
            end
            if (heat_wide > P_W'(LIMIT)) begin
               heat_in = LIMIT;
               sat_in  = 1'b1;
            end else begin
               heat_in = heat_wide[POWER_BITS-1:0];
            end
         end
      end
   end

   assign rdy_out = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rdy_out) begin
         out_valid_ff <= vp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out && vp_ff) begin
         heat_ff <= heat_in;
         sat_ff  <= sat_in;
         upd_ff  <= upd_p_ff;
      end
   end

   assign rsp_tvalid                = out_valid_ff;
   assign rsp_tdata                 = RSP_W'(heat_ff);
   assign rsp_tuser[USER_UPDATED]   = upd_ff;
   assign rsp_tuser[USER_SATURATED] = sat_ff;

   // ---------------- checks
   a_skip_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[USER_UPDATED]) |->
         (rsp_tdata == '0) && !rsp_tuser[USER_SATURATED])
      else $error("skipped word carries a nonzero output");

   a_sat_is_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[USER_SATURATED]) |->
         (rsp_tdata[POWER_BITS-1:0] == LIMIT))
      else $error("saturated word not clamped to the limit");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v0_ff)
      else $error("accepted req word lost at the first stage");

   a_idle_run: assert property (@(posedge clock) disable iff (reset)
      (vp_ff && !run_p_ff) |-> (heat_in == '0) && !sat_in)
      else $error("word with no evaluation produced output");

endmodule

// ----- test/roc_checker.sv -----
// Checker for the radiator output correction: predicts each rsp word and compares it.
module roc_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [roc_pkg::REQ_W-1:0]  req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [roc_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic [roc_pkg::USER_W-1:0] rsp_tuser,
   output int                         errors,
   output int                         pending
);
   import roc_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [POWER_BITS-1:0] heat;
      logic                  upd;
      logic                  sat;
   } heat_result_type;

   heat_result_type heat_fifo[$];
   logic [63:0]     root_q30[1:FRAC_BITS];
   longint          log_ratio_den;

   // floor(sqrt(v)), digit by digit
   function automatic logic [63:0] sqrt_floor(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // log2(x) for x >= 1 in Q(FRAC_BITS): leading one plus repeated squaring
   function automatic longint log2_fixed_q(input logic [63:0] x);
      int          p;
      logic [63:0] y;
      logic [63:0] fr;
      p = 0;
      for (int i = 0; i < 64; i++) if (x[i]) p = i;
      y = (p >= Q_BITS) ? (x >> (p - Q_BITS)) : (x << (Q_BITS - p));
      fr = '0;
      for (int k = 0; k < FRAC_BITS; k++) begin
         y = (y * y) >> Q_BITS;
         fr = fr << 1;
         if (y >= (64'd2 << Q_BITS)) begin
            y = y >> 1;
            fr[0] = 1'b1;
         end
      end
      return longint'((64'(p) << FRAC_BITS) | fr);
   endfunction

   // Expected result word for one req word
   function automatic heat_result_type predict_heat(input logic [REQ_W-1:0] w);
      longint          flow, ret, room, diff, lr, e, n, s;
      logic [63:0]     dd, f, m, prod, rated, heat;
      heat_result_type res;
      flow  = $signed(w[TEMP_BITS-1:0]);
      ret   = $signed(w[2*TEMP_BITS-1:TEMP_BITS]);
      room  = $signed(w[3*TEMP_BITS-1:2*TEMP_BITS]);
      rated = 64'(w[3*TEMP_BITS+POWER_BITS-1:3*TEMP_BITS]);
      res = '0;
      // any non-positive temperature skips the item
      if (flow <= 0 || ret <= 0 || room <= 0) return res;
      res.upd = 1'b1;
      diff = flow + ret - 2 * room;
      dd = (diff < 0) ? 64'(-diff) : 64'(diff);
      if (dd == 0 || rated == 0) return res;
      lr = log2_fixed_q(dd) - log_ratio_den;
      e  = (EXP_NUM * lr) / EXP_DEN;
      // floor split of the exponent
      n  = e >>> FRAC_BITS;
      f  = 64'(e) & ((64'd1 << FRAC_BITS) - 1);
      m  = 64'd1 << Q_BITS;
      for (int k = 1; k <= FRAC_BITS; k++) begin
         if (f[FRAC_BITS-k]) m = (m * root_q30[k]) >> Q_BITS;
      end
      prod = rated * m;
      if (n > Q_BITS) begin
         heat = '1;
      end else begin
         s = Q_BITS - n;
         heat = (s >= 64) ? 64'd0 : (prod >> s);
      end
      if (heat > 64'((1 << POWER_BITS) - 1)) begin
         res.heat = '1;
         res.sat  = 1'b1;
      end else begin
         res.heat = heat[POWER_BITS-1:0];
      end
      return res;
   endfunction

   // roots of two for the fraction bits, and log2 of the ratio denominator
   initial begin
      logic [63:0] r;
      r = 64'd2 << Q_BITS;
      for (int k = 1; k <= FRAC_BITS; k++) begin
         r = sqrt_floor(r << Q_BITS);
         root_q30[k] = r;
      end
      log_ratio_den = log2_fixed_q(64'(RATIO_DEN));
      errors  = 0;
      pending = 0;
   end

   // watch both channels at each rising edge
   always @(posedge clock) begin
      heat_result_type want;
      heat_result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) heat_fifo.push_back(predict_heat(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.heat = rsp_tdata[POWER_BITS-1:0];
            got.upd  = rsp_tuser[USER_UPDATED];
            got.sat  = rsp_tuser[USER_SATURATED];
            if (heat_fifo.size() == 0) begin
               if (errors < MAX_REPORTS)
                  $display("checker: rsp word with none expected: heat=%0d upd=%0b sat=%0b",
                           got.heat, got.upd, got.sat);
               errors = errors + 1;
            end else begin
               want = heat_fifo.pop_front();
               if (got !== want) begin
                  if (errors < MAX_REPORTS)
                     $display({"checker: mismatch: expected heat=%0d upd=%0b sat=%0b,",
                               " got heat=%0d upd=%0b sat=%0b"},
                              want.heat, want.upd, want.sat, got.heat, got.upd, got.sat);
                  errors = errors + 1;
               end
            end
         end
         pending = heat_fifo.size();
      end
   end

endmodule

// ----- test/tb.sv -----
// Stimulus and verdict for the radiator output correction block.
module tb;
   import roc_pkg::*;

   localparam int N_RANDOM   = 430;
   localparam int CALM_TAIL  = 80;
   localparam int DRAIN_WAIT = 60;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic [USER_W-1:0] rsp_tuser;
   logic              idle_on    = 1'b1;
   int                errors;
   int                pending;
   int                stall_left = 0;

   always #10 clock = ~clock;

   radiator_output_correction DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   roc_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .errors     (errors),
      .pending    (pending)
   );

   // Receiver: random stall bursts while idling is on
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // One req word; entered and left at a falling edge
   task automatic send_temps(input logic [15:0] flow, input logic [15:0] ret,
                             input logic [15:0] room, input logic [15:0] rated);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rated, room, ret, flow};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Well-formed items mostly, with some raw noise
   task automatic send_random_temps();
      logic [15:0] flow, ret, room, rated;
      int          kind;
      kind  = $urandom_range(0, 99);
      rated = 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         rated = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'hFFFF;
      end else if ($urandom_range(0, 9) == 0) begin
         rated = 16'($urandom_range(1, 300));
      end
      if (kind < 55) begin
         flow = 16'($urandom_range(1, 32767));
         ret  = 16'($urandom_range(1, 32767));
         room = 16'($urandom_range(1, 32767));
      end else if (kind < 72) begin
         // typical heating: room about 20 C, water 30..80 C
         room = 16'($urandom_range(1500, 2500));
         flow = 16'($urandom_range(3000, 8000));
         ret  = 16'($urandom_range(2500, 7500));
      end else if (kind < 85) begin
         // small differences around the room temperature
         room = 16'($urandom_range(100, 30000));
         flow = room + 16'($urandom_range(0, 40));
         ret  = room - 16'($urandom_range(0, 40));
      end else begin
         flow = 16'($urandom);
         ret  = 16'($urandom);
         room = 16'($urandom);
      end
      send_temps(flow, ret, room, rated);
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // skipped items
      send_temps(16'd0,     16'd5000,  16'd2000,  16'd1000);
      send_temps(16'd6000,  16'hFFFF,  16'd2000,  16'd1000);
      send_temps(16'd6000,  16'd5000,  16'd0,     16'd1000);
      send_temps(16'd6000,  16'd5000,  16'h8000,  16'hFFFF);
      send_temps(16'h8000,  16'h8000,  16'h8000,  16'hFFFF);
      send_temps(16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF);
      // zero difference
      send_temps(16'h7FFF,  16'h7FFF,  16'h7FFF,  16'hFFFF);
      send_temps(16'd1,     16'd1,     16'd1,     16'd1234);
      send_temps(16'd2100,  16'd1900,  16'd2000,  16'd500);
      // zero rating
      send_temps(16'd7000,  16'd6000,  16'd2000,  16'd0);
      // exactly fifty kelvin: output equals the rating
      send_temps(16'd7000,  16'd7000,  16'd2000,  16'd1500);
      send_temps(16'd7000,  16'd7000,  16'd2000,  16'hFFFF);
      // smallest nonzero difference
      send_temps(16'd2001,  16'd2000,  16'd2000,  16'hFFFF);
      send_temps(16'd2001,  16'd2000,  16'd2000,  16'd1);
      // largest differences, both signs; saturating at the top rating
      send_temps(16'h7FFF,  16'h7FFF,  16'd1,     16'hFFFF);
      send_temps(16'd1,     16'd1,     16'h7FFF,  16'hFFFF);
      send_temps(16'h7FFF,  16'h7FFF,  16'd1,     16'd5000);
      send_temps(16'h7FFF,  16'h7FFF,  16'd1,     16'd1);
      // typical room cases
      send_temps(16'd7500,  16'd6500,  16'd2000,  16'd1800);
      send_temps(16'd4500,  16'd3500,  16'd2100,  16'd2200);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 2) begin
            // hold off until the pipe has drained
            req_tvalid <= 1'b0;
            while (pending != 0) @(negedge clock);
         end
         if (i == N_RANDOM - CALM_TAIL) idle_on <= 1'b0;
         send_random_temps();
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (errors == 0 && pending == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #5000000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
